[hdl/graph_polyline_tessellator_unit_macros.svh]
// Assertion macros for the tessellator controller (gptu_ctrl).
`ifndef GRAPH_POLYLINE_TESSELLATOR_UNIT_MACROS_SVH
`define GRAPH_POLYLINE_TESSELLATOR_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define GPTU_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define GPTU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define GPTU_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define GPTU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

[hdl/gptu_pkg.sv]
package gptu_pkg;

	localparam int MAX_SAMPLES = 1024;
	localparam int CNT_W       = 11;
	localparam int COORD_W     = 20;
	localparam int DIV_NUM_W   = 44;
	localparam int DIV_DEN_W   = 30;
	localparam int DIV_STEPS   = DIV_NUM_W - 1;
	localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
	localparam int SQ_ROOT_W   = 29;
	localparam int SQ_RAD_W    = 2 * SQ_ROOT_W;
	localparam int SQ_CNT_W    = $clog2(SQ_ROOT_W);
	localparam int FILL_LAST   = 5;
	localparam int STROKE_LAST = 11;

	localparam logic [2:0] REG_BOX_LEFT      = 3'd0;
	localparam logic [2:0] REG_BOX_TOP       = 3'd1;
	localparam logic [2:0] REG_BOX_WIDTH     = 3'd2;
	localparam logic [2:0] REG_BOX_HEIGHT    = 3'd3;
	localparam logic [2:0] REG_LINE_WIDTH    = 3'd4;
	localparam logic [2:0] REG_SCALE_FACTOR  = 3'd5;
	localparam logic [2:0] REG_RIGHT_TO_LEFT = 3'd6;
	localparam logic [2:0] REG_SAMPLE_COUNT  = 3'd7;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_MUL,
		ST_PXDIV,
		ST_PXWAIT,
		ST_DIFF,
		ST_SQ,
		ST_SUM,
		ST_ROOT,
		ST_ROOTWAIT,
		ST_NXDIV,
		ST_NXWAIT,
		ST_NYDIV,
		ST_NYWAIT,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		DSEL_PX,
		DSEL_NX,
		DSEL_NY
	} div_sel_t;

	typedef struct packed {
		logic signed [15:0] box_left;
		logic signed [15:0] box_top;
		logic [14:0]        box_width;
		logic [14:0]        box_height;
		logic [10:0]        line_width;
		logic [9:0]         scale_factor;
		logic               right_to_left;
		logic [10:0]        sample_count;
	} cfg_t;

	typedef struct packed {
		logic     load;
		logic     idx_sat;
		logic     idx_keep;
		logic     first_store;
		logic     div_start;
		div_sel_t div_sel;
		logic     px_cap;
		logic     nx_cap;
		logic     ny_cap;
		logic     sqrt_start;
		logic     emit;
		logic     commit;
	} cmd_t;

	typedef struct packed {
		logic disabled;
		logic past_end;
		logic first;
		logic dzero;
		logic div_done;
		logic div_busy;
		logic sqrt_done;
		logic out_free;
		logic emit_last;
	} sts_t;

	function automatic logic signed [COORD_W-1:0] sat20(input logic signed [COORD_W+1:0] v);
		logic signed [COORD_W+1:0] hi;
		logic signed [COORD_W+1:0] lo;
		hi = (COORD_W+2)'(2 ** (COORD_W - 1) - 1);
		lo = -(COORD_W+2)'(2 ** (COORD_W - 1));
		if (v > hi)
			return hi[COORD_W-1:0];
		if (v < lo)
			return lo[COORD_W-1:0];
		return v[COORD_W-1:0];
	endfunction

endpackage

[hdl/graph_polyline_tessellator_unit.sv]
// Steps: the first sample of a graph goes to idle after the x-position divide; a segment runs
// the x divide, a square root and then the normal x and y divides before its first vertex.
// One request at a time; a disabled or past-the-count sample returns to idle from the check, a
// zero-length segment skips the root and normal divides, and output stalls hold vertex emission.
// Reset: arst_n clears the sample index and previous point and returns registers to defaults.
module graph_polyline_tessellator_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [15:0] sample_value
	input  logic        s_axis_tuser,   // [0] start_of_graph
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // [19:0] vertex_x, [39:20] vertex_y
	output logic        m_axis_tlast,   // last_vertex
	output logic        m_axis_tuser,   // [0] is_stroke
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	gptu_pkg::cfg_t cfg_q;
	gptu_pkg::cmd_t cmd;
	gptu_pkg::sts_t sts;
	logic signed [19:0] vx;
	logic signed [19:0] vy;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.box_left      <= '0;
			cfg_q.box_top       <= '0;
			cfg_q.box_width     <= '0;
			cfg_q.box_height    <= '0;
			cfg_q.line_width    <= 11'd16;
			cfg_q.scale_factor  <= 10'd256;
			cfg_q.right_to_left <= 1'b0;
			cfg_q.sample_count  <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				gptu_pkg::REG_BOX_LEFT:      cfg_q.box_left      <= cfg_data;
				gptu_pkg::REG_BOX_TOP:       cfg_q.box_top       <= cfg_data;
				gptu_pkg::REG_BOX_WIDTH:     cfg_q.box_width     <= cfg_data[14:0];
				gptu_pkg::REG_BOX_HEIGHT:    cfg_q.box_height    <= cfg_data[14:0];
				gptu_pkg::REG_LINE_WIDTH:    cfg_q.line_width    <= cfg_data[10:0];
				gptu_pkg::REG_SCALE_FACTOR:  cfg_q.scale_factor  <= cfg_data[9:0];
				gptu_pkg::REG_RIGHT_TO_LEFT: cfg_q.right_to_left <= cfg_data[0];
				gptu_pkg::REG_SAMPLE_COUNT:  cfg_q.sample_count  <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	gptu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	gptu_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_value   (s_axis_tdata),
		.in_start   (s_axis_tuser),
		.cmd        (cmd),
		.sts        (sts),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_x      (vx),
		.out_y      (vy),
		.out_stroke (m_axis_tuser),
		.out_last   (m_axis_tlast)
	);

	assign m_axis_tdata = {vy, vx};

endmodule

[hdl/gptu_div.sv]
module gptu_div (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      start,
	input  logic signed [gptu_pkg::DIV_NUM_W-1:0]     num,
	input  logic [gptu_pkg::DIV_DEN_W-1:0]            den,
	output logic signed [gptu_pkg::DIV_NUM_W-1:0]     quo,
	output logic                                      busy,
	output logic                                      done
);

	logic [gptu_pkg::DIV_NUM_W-2:0] quo_q;
	logic [gptu_pkg::DIV_NUM_W-2:0] mag;
	logic [gptu_pkg::DIV_DEN_W-1:0] rem_q;
	logic [gptu_pkg::DIV_DEN_W-1:0] den_q;
	logic [gptu_pkg::DIV_DEN_W:0]   r2;
	logic [gptu_pkg::DIV_DEN_W:0]   rnext;
	logic                           ge;
	logic                           neg_q;
	logic [gptu_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                           busy_q;
	logic                           done_q;

	// floor division of a negative value: ~(~num / den)
	assign mag   = num[gptu_pkg::DIV_NUM_W-1] ? ~num[gptu_pkg::DIV_NUM_W-2:0]
	                                          : num[gptu_pkg::DIV_NUM_W-2:0];
	assign r2    = {rem_q, quo_q[gptu_pkg::DIV_NUM_W-2]};
	assign ge    = (r2 >= {1'b0, den_q});
	assign rnext = ge ? (r2 - {1'b0, den_q}) : r2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == gptu_pkg::DIV_CNT_W'(gptu_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= mag;
			rem_q <= '0;
			den_q <= den;
			neg_q <= num[gptu_pkg::DIV_NUM_W-1];
		end else if (busy_q) begin
			rem_q <= rnext[gptu_pkg::DIV_DEN_W-1:0];
			quo_q <= {quo_q[gptu_pkg::DIV_NUM_W-3:0], ge};
		end
	end

	assign quo  = neg_q ? ~$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
	assign busy = busy_q;
	assign done = done_q;

endmodule

[hdl/gptu_sqrt.sv]
module gptu_sqrt (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [gptu_pkg::SQ_RAD_W-1:0]     rad,
	output logic [gptu_pkg::SQ_ROOT_W-1:0]    root,
	output logic                              done
);

	logic [gptu_pkg::SQ_RAD_W-1:0]  rad_q;
	logic [gptu_pkg::SQ_ROOT_W:0]   rem_q;
	logic [gptu_pkg::SQ_ROOT_W-1:0] root_q;
	logic [gptu_pkg::SQ_ROOT_W+2:0] r2;
	logic [gptu_pkg::SQ_ROOT_W+2:0] trial;
	logic                           ge;
	logic [gptu_pkg::SQ_ROOT_W+2:0] rnext;
	logic [gptu_pkg::SQ_CNT_W-1:0]  cnt_q;
	logic                           busy_q;
	logic                           done_q;

	assign r2    = {rem_q, rad_q[gptu_pkg::SQ_RAD_W-1 -: 2]};
	assign trial = {1'b0, root_q, 2'b01};
	assign ge    = (r2 >= trial);
	assign rnext = ge ? (r2 - trial) : r2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == gptu_pkg::SQ_CNT_W'(gptu_pkg::SQ_ROOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[gptu_pkg::SQ_RAD_W-3:0], 2'b00};
			rem_q  <= rnext[gptu_pkg::SQ_ROOT_W:0];
			root_q <= {root_q[gptu_pkg::SQ_ROOT_W-2:0], ge};
		end
	end

	assign root = root_q;
	assign done = done_q;

endmodule

[hdl/gptu_dp.sv]
module gptu_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  gptu_pkg::cfg_t        cfg,
	input  logic [15:0]           in_value,
	input  logic                  in_start,
	input  gptu_pkg::cmd_t        cmd,
	output gptu_pkg::sts_t        sts,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic signed [19:0]    out_x,
	output logic signed [19:0]    out_y,
	output logic                  out_stroke,
	output logic                  out_last
);

	logic [15:0]        v_q;
	logic [10:0]        idx_q;
	logic [10:0]        sample_index_q;
	logic [10:0]        n_c;
	logic [10:0]        m_c;
	logic signed [19:0] prevx_q;
	logic signed [19:0] prevy_q;

	logic signed [16:0] left_c;
	logic signed [16:0] right_c;
	logic signed [16:0] edge_c;
	logic signed [28:0] em_c;
	logic [25:0]        iw_c;
	logic signed [29:0] x_c;
	logic signed [16:0] bottom_c;
	logic signed [33:0] bot16_c;
	logic signed [33:0] top16_c;
	logic [30:0]        vh_c;
	logic [14:0]        minv_c;
	logic [29:0]        p_c;
	logic signed [33:0] lo_c;
	logic signed [33:0] hi_c;
	logic signed [33:0] yr_c;
	logic signed [33:0] y_c;
	logic signed [27:0] bs_c;

	logic signed [29:0] x_s1;
	logic signed [33:0] y_s1;
	logic signed [27:0] bs_s1;
	logic [20:0]        lws_s1;
	logic signed [40:0] xs_s2;
	logic signed [44:0] ys_s2;
	logic signed [27:0] bsr_c;
	logic signed [19:0] base_s2;
	logic signed [45:0] ysr_c;
	logic signed [19:0] py_s3;

	logic signed [19:0] px_q;
	logic signed [19:0] nx_q;
	logic signed [19:0] ny_q;
	logic signed [20:0] dx_q;
	logic signed [20:0] dy_q;
	logic signed [41:0] dx2_q;
	logic signed [41:0] dy2_q;
	logic signed [42:0] pnx_q;
	logic signed [42:0] pny_q;
	logic [41:0]        d_q;

	logic signed [43:0] div_num_c;
	logic [29:0]        div_den_c;
	logic signed [43:0] div_quo;
	logic               div_busy;
	logic               div_done;
	logic [28:0]        root;
	logic               sqrt_done;

	logic [3:0]         k_q;
	logic               emit_last_c;
	logic               out_free_c;
	logic signed [21:0] ax_c, ay_c, px_c, py_c, bx_c, nx_c, ny_c;
	logic signed [21:0] vx_c;
	logic signed [21:0] vy_c;

	logic               out_valid_q;
	logic signed [19:0] out_x_q;
	logic signed [19:0] out_y_q;
	logic               out_stroke_q;
	logic               out_last_q;

	assign n_c = (32'(cfg.sample_count) > gptu_pkg::MAX_SAMPLES)
	             ? gptu_pkg::CNT_W'(gptu_pkg::MAX_SAMPLES) : cfg.sample_count;
	assign m_c = n_c - 11'd1;

	always_comb begin
		left_c   = $signed({cfg.box_left[15], cfg.box_left});
		right_c  = left_c + $signed({2'b00, cfg.box_width});
		edge_c   = cfg.right_to_left ? right_c : left_c;
		em_c     = edge_c * $signed({1'b0, m_c});
		iw_c     = idx_q * cfg.box_width;
		x_c      = cfg.right_to_left ? ($signed({em_c[28], em_c}) - $signed({4'b0, iw_c}))
		                             : ($signed({em_c[28], em_c}) + $signed({4'b0, iw_c}));
		bottom_c = $signed({cfg.box_top[15], cfg.box_top}) + $signed({2'b00, cfg.box_height});
		bot16_c  = $signed({bottom_c[16], bottom_c, 16'h0000});
		top16_c  = $signed({cfg.box_top[15], cfg.box_top[15], cfg.box_top, 16'h0000});
		vh_c     = v_q * cfg.box_height;
		minv_c   = ({4'b0, cfg.line_width} < cfg.box_height) ? {4'b0, cfg.line_width}
		                                                     : cfg.box_height;
		p_c      = {minv_c, 15'b0};
		lo_c     = top16_c + $signed({4'b0, p_c});
		hi_c     = bot16_c - $signed({4'b0, p_c});
		yr_c     = bot16_c - $signed({3'b0, vh_c});
		if (yr_c < lo_c)
			y_c = lo_c;
		else if (yr_c > hi_c)
			y_c = hi_c;
		else
			y_c = yr_c;
		bs_c     = bottom_c * $signed({1'b0, cfg.scale_factor});
		bsr_c    = bs_s1 + 28'sd128;
		ysr_c    = $signed({ys_s2[44], ys_s2}) + 46'sd8388608;
	end

	always_ff @(posedge clk) begin
		x_s1    <= x_c;
		y_s1    <= y_c;
		bs_s1   <= bs_c;
		lws_s1  <= cfg.line_width * cfg.scale_factor;
		xs_s2   <= x_s1 * $signed({1'b0, cfg.scale_factor});
		ys_s2   <= y_s1 * $signed({1'b0, cfg.scale_factor});
		base_s2 <= bsr_c[27:8];
		py_s3   <= ysr_c[43:24];
		dx_q    <= $signed({px_q[19], px_q}) - $signed({prevx_q[19], prevx_q});
		dy_q    <= $signed({py_s3[19], py_s3}) - $signed({prevy_q[19], prevy_q});
		dx2_q   <= dx_q * dx_q;
		dy2_q   <= dy_q * dy_q;
		pnx_q   <= dy_q * $signed({1'b0, lws_s1});
		pny_q   <= dx_q * $signed({1'b0, lws_s1});
		d_q     <= $unsigned(dx2_q) + $unsigned(dy2_q);
	end

	always_comb begin
		case (cmd.div_sel)
			gptu_pkg::DSEL_PX: begin
				div_num_c = $signed({{2{xs_s2[40]}}, xs_s2, 1'b0}) + $signed({25'b0, m_c, 8'b0});
				div_den_c = {10'b0, m_c, 9'b0};
			end
			gptu_pkg::DSEL_NX: begin
				div_num_c = $signed(44'd0) - $signed({pnx_q[42], pnx_q}) + $signed({15'b0, root});
				div_den_c = {root, 1'b0};
			end
			gptu_pkg::DSEL_NY: begin
				div_num_c = $signed({pny_q[42], pny_q}) + $signed({15'b0, root});
				div_den_c = {root, 1'b0};
			end
			default: begin
				div_num_c = '0;
				div_den_c = '0;
			end
		endcase
	end

	gptu_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num_c),
		.den    (div_den_c),
		.quo    (div_quo),
		.busy   (div_busy),
		.done   (div_done)
	);

	gptu_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.sqrt_start),
		.rad    ({d_q, 16'h0000}),
		.root   (root),
		.done   (sqrt_done)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			v_q <= in_value;
		end
		if (cmd.px_cap)
			px_q <= div_quo[19:0];
		if (cmd.nx_cap)
			nx_q <= div_quo[19:0];
		if (cmd.ny_cap)
			ny_q <= div_quo[19:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q          <= '0;
			sample_index_q <= '0;
			prevx_q        <= '0;
			prevy_q        <= '0;
			k_q            <= '0;
		end else begin
			if (cmd.load) begin
				idx_q <= in_start ? 11'd0 : sample_index_q;
				k_q   <= '0;
			end
			if (cmd.idx_sat)
				sample_index_q <= (idx_q < n_c) ? idx_q + 11'd1 : idx_q;
			if (cmd.idx_keep)
				sample_index_q <= idx_q;
			if (cmd.first_store || cmd.commit) begin
				prevx_q        <= px_q;
				prevy_q        <= py_s3;
				sample_index_q <= idx_q + 11'd1;
			end
			if (cmd.emit)
				k_q <= k_q + 4'd1;
		end
	end

	always_comb begin
		ax_c = $signed({{2{prevx_q[19]}}, prevx_q});
		ay_c = $signed({{2{prevy_q[19]}}, prevy_q});
		px_c = $signed({{2{px_q[19]}}, px_q});
		py_c = $signed({{2{py_s3[19]}}, py_s3});
		bx_c = $signed({{2{base_s2[19]}}, base_s2});
		nx_c = $signed({{2{nx_q[19]}}, nx_q});
		ny_c = $signed({{2{ny_q[19]}}, ny_q});
		case (k_q)
			4'd0:    begin vx_c = ax_c;        vy_c = ay_c;        end
			4'd1:    begin vx_c = px_c;        vy_c = py_c;        end
			4'd2:    begin vx_c = ax_c;        vy_c = bx_c;        end
			4'd3:    begin vx_c = px_c;        vy_c = py_c;        end
			4'd4:    begin vx_c = px_c;        vy_c = bx_c;        end
			4'd5:    begin vx_c = ax_c;        vy_c = bx_c;        end
			4'd6:    begin vx_c = ax_c - nx_c; vy_c = ay_c - ny_c; end
			4'd7:    begin vx_c = ax_c + nx_c; vy_c = ay_c + ny_c; end
			4'd8:    begin vx_c = px_c - nx_c; vy_c = py_c - ny_c; end
			4'd9:    begin vx_c = ax_c + nx_c; vy_c = ay_c + ny_c; end
			4'd10:   begin vx_c = px_c + nx_c; vy_c = py_c + ny_c; end
			4'd11:   begin vx_c = px_c - nx_c; vy_c = py_c - ny_c; end
			default: begin vx_c = ax_c;        vy_c = ay_c;        end
		endcase
	end

	assign emit_last_c = (d_q == '0) ? (k_q == 4'(gptu_pkg::FILL_LAST))
	                                 : (k_q == 4'(gptu_pkg::STROKE_LAST));
	assign out_free_c  = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_x_q      <= gptu_pkg::sat20(vx_c);
			out_y_q      <= gptu_pkg::sat20(vy_c);
			out_stroke_q <= (k_q > 4'(gptu_pkg::FILL_LAST));
			out_last_q   <= emit_last_c;
		end
	end

	always_comb begin
		sts.disabled  = (n_c < 11'd2) || (cfg.box_width == '0) || (cfg.box_height == '0);
		sts.past_end  = (idx_q >= n_c);
		sts.first     = (idx_q == '0);
		sts.dzero     = (d_q == '0);
		sts.div_done  = div_done;
		sts.div_busy  = div_busy;
		sts.sqrt_done = sqrt_done;
		sts.out_free  = out_free_c;
		sts.emit_last = emit_last_c;
	end

	assign out_valid  = out_valid_q;
	assign out_x      = out_x_q;
	assign out_y      = out_y_q;
	assign out_stroke = out_stroke_q;
	assign out_last   = out_last_q;

endmodule

[hdl/gptu_ctrl.sv]
`include "graph_polyline_tessellator_unit_macros.svh"

module gptu_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output gptu_pkg::cmd_t  cmd,
	input  gptu_pkg::sts_t  sts
);

	gptu_pkg::state_t state_q;
	gptu_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= gptu_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			gptu_pkg::ST_IDLE:     if (in_valid) state_d = gptu_pkg::ST_CHECK;
			gptu_pkg::ST_CHECK: begin
				if (sts.disabled || sts.past_end)
					state_d = gptu_pkg::ST_IDLE;
				else
					state_d = gptu_pkg::ST_MUL;
			end
			gptu_pkg::ST_MUL:      state_d = gptu_pkg::ST_PXDIV;
			gptu_pkg::ST_PXDIV:    state_d = gptu_pkg::ST_PXWAIT;
			gptu_pkg::ST_PXWAIT:   if (sts.div_done) state_d = gptu_pkg::ST_DIFF;
			gptu_pkg::ST_DIFF:     state_d = sts.first ? gptu_pkg::ST_IDLE : gptu_pkg::ST_SQ;
			gptu_pkg::ST_SQ:       state_d = gptu_pkg::ST_SUM;
			gptu_pkg::ST_SUM:      state_d = gptu_pkg::ST_ROOT;
			gptu_pkg::ST_ROOT:     state_d = sts.dzero ? gptu_pkg::ST_EMIT : gptu_pkg::ST_ROOTWAIT;
			gptu_pkg::ST_ROOTWAIT: if (sts.sqrt_done) state_d = gptu_pkg::ST_NXDIV;
			gptu_pkg::ST_NXDIV:    state_d = gptu_pkg::ST_NXWAIT;
			gptu_pkg::ST_NXWAIT:   if (sts.div_done) state_d = gptu_pkg::ST_NYDIV;
			gptu_pkg::ST_NYDIV:    state_d = gptu_pkg::ST_NYWAIT;
			gptu_pkg::ST_NYWAIT:   if (sts.div_done) state_d = gptu_pkg::ST_EMIT;
			gptu_pkg::ST_EMIT:     if (sts.out_free && sts.emit_last) state_d = gptu_pkg::ST_IDLE;
			default:               state_d = gptu_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			gptu_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			gptu_pkg::ST_CHECK: begin
				cmd.idx_sat  = sts.disabled;
				cmd.idx_keep = !sts.disabled && sts.past_end;
			end
			gptu_pkg::ST_PXDIV: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = gptu_pkg::DSEL_PX;
			end
			gptu_pkg::ST_PXWAIT: cmd.px_cap = sts.div_done;
			gptu_pkg::ST_DIFF:   cmd.first_store = sts.first;
			gptu_pkg::ST_ROOT:   cmd.sqrt_start = !sts.dzero;
			gptu_pkg::ST_NXDIV: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = gptu_pkg::DSEL_NX;
			end
			gptu_pkg::ST_NXWAIT: cmd.nx_cap = sts.div_done;
			gptu_pkg::ST_NYDIV: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = gptu_pkg::DSEL_NY;
			end
			gptu_pkg::ST_NYWAIT: cmd.ny_cap = sts.div_done;
			gptu_pkg::ST_EMIT: begin
				cmd.emit   = sts.out_free;
				cmd.commit = sts.out_free && sts.emit_last;
			end
			default: begin
				cmd      = '0;
				in_ready = 1'b0;
			end
		endcase
	end

	`GPTU_ASSERT_IMPLY(a_emit_slot_free, clk, arst_n, cmd.emit, sts.out_free, "vertex loaded into full output slot")
	`GPTU_ASSERT_IMPLY(a_commit_on_last, clk, arst_n, cmd.commit, cmd.emit && sts.emit_last, "commit without final vertex")
	`GPTU_ASSERT_IMPLY(a_div_idle_start, clk, arst_n, cmd.div_start, !sts.div_busy, "divider restarted while busy")
	`GPTU_ASSERT_NEXT(a_no_emit_after_commit, clk, arst_n, cmd.commit, !cmd.emit, "vertex emitted after final vertex")

endmodule

[dv/graph_polyline_tessellator_unit_tb.sv]
`timescale 1ns / 100ps

module graph_polyline_tessellator_unit_tb;

	typedef struct {
		logic signed [19:0] x;
		logic signed [19:0] y;
		logic               stroke;
		logic               last;
	} vertex_t;

	class vertex_scoreboard;
		vertex_t pending[$];
		int      errors;
		int      reported;

		logic signed [15:0] left, top;
		logic [14:0]        width, height;
		logic [10:0]        lw;
		logic [9:0]         scale;
		logic               rtl;
		logic [10:0]        count;
		longint             prev_x, prev_y;
		int                 index;

		function void clear();
			pending.delete();
			errors = 0;
			reported = 0;
			left = 0;
			top = 0;
			width = 0;
			height = 0;
			lw = 16;
			scale = 256;
			rtl = 0;
			count = 0;
			prev_x = 0;
			prev_y = 0;
			index = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [15:0] value);
			case (idx)
				gptu_pkg::REG_BOX_LEFT:      left = value;
				gptu_pkg::REG_BOX_TOP:       top = value;
				gptu_pkg::REG_BOX_WIDTH:     width = value[14:0];
				gptu_pkg::REG_BOX_HEIGHT:    height = value[14:0];
				gptu_pkg::REG_LINE_WIDTH:    lw = value[10:0];
				gptu_pkg::REG_SCALE_FACTOR:  scale = value[9:0];
				gptu_pkg::REG_RIGHT_TO_LEFT: rtl = value[0];
				gptu_pkg::REG_SAMPLE_COUNT:  count = value[10:0];
				default: ;
			endcase
		endfunction

		function longint fdiv(longint num, longint den);
			longint q;
			q = num / den;
			if ((num % den) != 0 && ((num < 0) != (den < 0)))
				q--;
			return q;
		endfunction

		function longint rdiv(longint num, longint den);
			return fdiv(2 * num + den, 2 * den);
		endfunction

		function longint root(longint unsigned v);
			longint unsigned res, b;
			res = 0;
			b = 64'd1 << 62;
			while (b > v)
				b >>= 2;
			while (b != 0) begin
				if (v >= res + b) begin
					v -= res + b;
					res = (res >> 1) + b;
				end else begin
					res >>= 1;
				end
				b >>= 2;
			end
			return res;
		endfunction

		function logic signed [19:0] sat(longint v);
			if (v > 524287)
				return 20'sh7ffff;
			if (v < -524288)
				return 20'sh80000;
			return v[19:0];
		endfunction

		function void push(longint x, longint y, logic stroke);
			vertex_t v;
			v.x = sat(x);
			v.y = sat(y);
			v.stroke = stroke;
			v.last = 0;
			pending.insert(pending.size(), v);
		endfunction

		function void note_sample(logic sog, logic [15:0] sv);
			longint n, s, w, h, l, i, m, xx, yy, p, lo, hi, bot, px, py, base;
			longint dx, dy, len8, nx, ny;
			longint unsigned d;
			n = (count > gptu_pkg::MAX_SAMPLES) ? gptu_pkg::MAX_SAMPLES : count;
			s = scale;
			w = width;
			h = height;
			l = lw;
			if (sog)
				index = 0;
			if (n < 2 || w == 0 || h == 0) begin
				if (index < n)
					index++;
				return;
			end
			if (index >= n)
				return;
			i = index;
			m = n - 1;
			if (rtl)
				xx = (longint'(left) + w) * m - i * w;
			else
				xx = longint'(left) * m + i * w;
			px = rdiv(xx * s, 256 * m);
			bot = longint'(top) + h;
			p = ((l < h) ? l : h) * 32768;
			lo = longint'(top) * 65536 + p;
			hi = bot * 65536 - p;
			yy = bot * 65536 - longint'(sv) * h;
			if (yy < lo)
				yy = lo;
			if (yy > hi)
				yy = hi;
			py = rdiv(yy * s, 256 * 65536);
			if (index > 0) begin
				base = rdiv(bot * s, 256);
				push(prev_x, prev_y, 0);
				push(px, py, 0);
				push(prev_x, base, 0);
				push(px, py, 0);
				push(px, base, 0);
				push(prev_x, base, 0);
				dx = px - prev_x;
				dy = py - prev_y;
				d = dx * dx + dy * dy;
				if (d != 0) begin
					len8 = root(d << 16);
					nx = rdiv(-dy * l * s, 2 * len8);
					ny = rdiv(dx * l * s, 2 * len8);
					push(prev_x - nx, prev_y - ny, 1);
					push(prev_x + nx, prev_y + ny, 1);
					push(px - nx, py - ny, 1);
					push(prev_x + nx, prev_y + ny, 1);
					push(px + nx, py + ny, 1);
					push(px - nx, py - ny, 1);
				end
				pending[$].last = 1;
			end
			prev_x = px;
			prev_y = py;
			index++;
		endfunction

		function void check_vertex(logic [39:0] data, logic tlast, logic tuser);
			vertex_t e;
			if (pending.size() == 0) begin
				errors++;
				if (reported < 10) begin
					reported++;
					$display("unexpected vertex x=%0d y=%0d", $signed(data[19:0]),
						$signed(data[39:20]));
				end
				return;
			end
			e = pending.pop_front();
			if (e.x !== data[19:0] || e.y !== data[39:20] || e.stroke !== tuser ||
					e.last !== tlast) begin
				errors++;
				if (reported < 10) begin
					reported++;
					$display("mismatch: exp x=%0d y=%0d s=%0b l=%0b got x=%0d y=%0d s=%0b l=%0b",
						e.x, e.y, e.stroke, e.last, $signed(data[19:0]),
						$signed(data[39:20]), tuser, tlast);
				end
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata;
	logic        s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic        m_axis_tuser;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;

	vertex_scoreboard sb;
	longint           cycles;
	bit               sink_quiet;

	graph_polyline_tessellator_unit dut (.*);

	initial clk = 0;
	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 3000000) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	always @(posedge clk)
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_vertex(m_axis_tdata, m_axis_tlast, m_axis_tuser);

	initial begin
		int gap;
		m_axis_tready = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (sink_quiet || $urandom_range(0, 3) == 0) begin
				m_axis_tready = 1;
			end else begin
				gap = $urandom_range(0, 15);
				m_axis_tready = (gap == 0);
				repeat (gap) @(negedge clk);
				m_axis_tready = 1;
				@(posedge clk);
				while (!m_axis_tvalid) @(posedge clk);
			end
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [15:0] value);
		@(negedge clk);
		cfg_valid = 1;
		cfg_index = idx;
		cfg_data = value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.write_reg(idx, value);
		@(negedge clk);
		cfg_valid = 0;
	endtask

	task automatic send_sample(logic sog, logic [15:0] value, bit quiet);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 15);
		repeat (gap) @(negedge clk);
		@(negedge clk);
		s_axis_tvalid = 1;
		s_axis_tuser = sog;
		s_axis_tdata = value;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note_sample(sog, value);
		@(negedge clk);
		s_axis_tvalid = 0;
	endtask

	task automatic drain();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic random_config(bit extreme);
		write_reg(gptu_pkg::REG_BOX_LEFT, extreme ? 16'h8000 : 16'($urandom_range(0, 4000)));
		write_reg(gptu_pkg::REG_BOX_TOP, extreme ? 16'h7fff : 16'($urandom_range(0, 4000)));
		write_reg(gptu_pkg::REG_BOX_WIDTH, extreme ? 16'h7fff : 16'($urandom_range(1, 8000)));
		write_reg(gptu_pkg::REG_BOX_HEIGHT, extreme ? 16'h7fff : 16'($urandom_range(1, 8000)));
		write_reg(gptu_pkg::REG_LINE_WIDTH, extreme ? 16'h07ff : 16'($urandom_range(0, 64)));
		write_reg(gptu_pkg::REG_SCALE_FACTOR,
			extreme ? 16'h03ff : 16'($urandom_range(256, 1023)));
		write_reg(gptu_pkg::REG_RIGHT_TO_LEFT, 16'($urandom_range(0, 1)));
		write_reg(gptu_pkg::REG_SAMPLE_COUNT, 16'($urandom_range(2, 12)));
	endtask

	initial begin
		int k, len;
		sb = new();
		sb.clear();
		cycles = 0;
		sink_quiet = 0;
		arst_n = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = 0;
		s_axis_tuser = 0;
		cfg_valid = 0;
		cfg_index = gptu_pkg::REG_BOX_LEFT;
		cfg_data = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// disabled graph at reset values
		send_sample(1, 16'h1234, 0);
		send_sample(0, 16'hffff, 0);
		drain();
		write_reg(gptu_pkg::REG_BOX_WIDTH, 16'd1600);
		write_reg(gptu_pkg::REG_BOX_HEIGHT, 16'd800);
		write_reg(gptu_pkg::REG_SAMPLE_COUNT, 16'd6);
		send_sample(1, 16'h0000, 0);
		send_sample(0, 16'hffff, 0);
		send_sample(0, 16'hffff, 0);
		send_sample(0, 16'h8000, 0);
		send_sample(0, 16'h0001, 0);
		send_sample(0, 16'h5555, 0);
		send_sample(0, 16'h7777, 0);
		drain();
		write_reg(gptu_pkg::REG_LINE_WIDTH, 16'd0);
		write_reg(gptu_pkg::REG_RIGHT_TO_LEFT, 16'd1);
		write_reg(gptu_pkg::REG_SAMPLE_COUNT, 16'd2047);
		write_reg(gptu_pkg::REG_SCALE_FACTOR, 16'd0);
		send_sample(1, 16'haaaa, 0);
		send_sample(0, 16'h5555, 0);
		drain();
		random_config(1);
		send_sample(1, 16'h0000, 0);
		send_sample(0, 16'hffff, 0);
		send_sample(0, 16'h1234, 0);
		drain();
		write_reg(gptu_pkg::REG_BOX_LEFT, 16'h7fff);
		write_reg(gptu_pkg::REG_BOX_TOP, 16'h8000);
		write_reg(gptu_pkg::REG_SAMPLE_COUNT, 16'd1);
		send_sample(1, 16'h4321, 0);
		send_sample(0, 16'h4321, 0);
		drain();

		for (k = 0; k < 18; k++) begin
			random_config(k == 7);
			if ($urandom_range(0, 5) == 0) begin
				drain();
				sink_quiet = 1;
			end
			len = sb.count + $urandom_range(0, 2);
			for (int j = 0; j < len; j++)
				send_sample(j == 0 || $urandom_range(0, 19) == 0,
					16'($urandom_range(0, 3) == 0 ? (j % 2 ? 16'h0 : 16'hffff) : $urandom),
					sink_quiet);
			drain();
			sink_quiet = 0;
		end
		drain();
		if (sb.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
